@@ sv/frat_pkg.sv @@
// types, constants and hash function shared by the flow aggregation table
package frat_pkg;

    localparam int BUCKET_BITS      = 10;
    localparam int WAYS             = 4;
    localparam int SOURCES_PER_FLOW = 4;

    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int NUM_ENTRIES = NUM_BUCKETS * WAYS;
    localparam int ENTRY_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_W      = (SOURCES_PER_FLOW > 1) ? $clog2(SOURCES_PER_FLOW) : 1;
    localparam int SRC_W       = $clog2(SOURCES_PER_FLOW + 1);

    // hash rotate amounts
    localparam int ROT_SRC_HI = 7;
    localparam int ROT_DST_HI = 13;
    localparam int ROT_DPORT  = 3;

    // flow status codes
    localparam logic [1:0] FLOW_NEW     = 2'd0;
    localparam logic [1:0] FLOW_MERGED  = 2'd1;
    localparam logic [1:0] FLOW_DROPPED = 2'd2;

    // source status codes
    localparam logic [1:0] SRC_UPDATED = 2'd0;
    localparam logic [1:0] SRC_ADDED   = 2'd1;
    localparam logic [1:0] SRC_NONE    = 2'd2;

    typedef struct packed {
        logic [31:0] exporter_addr;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flag_bits;
        logic [31:0] packet_count;
        logic [31:0] byte_count;
        logic [31:0] first_sec;
        logic [31:0] last_sec;
    } t_in;

    typedef struct packed {
        logic [1:0]  flow_status;
        logic [15:0] hash_value;
        logic [1:0]  source_status;
        logic [4:0]  source_total;
        logic [7:0]  merged_flags;
        logic [31:0] merged_start;
        logic [31:0] merged_end;
        logic [63:0] exporter_packets;
        logic [63:0] exporter_bytes;
        logic [63:0] exporter_records;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic [63:0]      addrs;
        logic [39:0]      ppr;
        logic [31:0]      start_t;
        logic [31:0]      end_t;
        logic [7:0]       flags;
        logic [SRC_W-1:0] total;
    } t_entry;

    typedef struct packed {
        logic [31:0] exporter;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [63:0] records;
    } t_slot;

    typedef t_entry [WAYS-1:0]             t_bucket_row;
    typedef t_slot  [SOURCES_PER_FLOW-1:0] t_slot_row;

    localparam int BUCKET_ROW_W = $bits(t_bucket_row);
    localparam int SLOT_ROW_W   = $bits(t_slot_row);

    // result of the merge logic toward the top level
    typedef struct packed {
        logic              bucket_we;
        logic              slot_we;
        logic [WAY_W-1:0]  way;
        t_bucket_row       bucket_row;
        t_slot_row         slot_row;
        t_out              result;
    } t_merge;

    function automatic logic [15:0] rol16(input logic [15:0] x, input int r);
        logic [31:0] d;
        d = {x, x} << r;
        return d[31:16];
    endfunction

    function automatic logic [15:0] key_hash(input t_in rec);
        return rec.src_ip[15:0] ^ rol16(rec.src_ip[31:16], ROT_SRC_HI)
             ^ rec.dst_ip[15:0] ^ rol16(rec.dst_ip[31:16], ROT_DST_HI)
             ^ rec.sport ^ rol16(rec.dport, ROT_DPORT)
             ^ {8'd0, rec.protocol};
    endfunction

endpackage

@@ sv/frat_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
module frat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/frat_merge.sv @@
// tag match, way allocation and exporter slot update for one bucket
module frat_merge (
    input  frat_pkg::t_in         i_rec,
    input  logic [15:0]           i_hash,
    input  frat_pkg::t_bucket_row i_bucket_row,
    input  frat_pkg::t_slot_row   i_slot_row,
    output frat_pkg::t_merge      o_merge
);

    logic [63:0]                     addrs;
    logic [39:0]                     ppr;
    logic                            found;
    logic                            has_free;
    logic [frat_pkg::WAY_W-1:0]      hit_way;
    logic [frat_pkg::WAY_W-1:0]      free_way;
    logic [frat_pkg::WAY_W-1:0]      way;
    logic                            drop;
    frat_pkg::t_entry                ent;
    logic [frat_pkg::SRC_W-1:0]      n;
    logic                            smatch;
    logic [frat_pkg::SLOT_W-1:0]     sidx;
    logic                            sadd;
    frat_pkg::t_slot                 slot;
    logic [1:0]                      sstat;

    assign addrs = {i_rec.src_ip, i_rec.dst_ip};
    assign ppr   = {i_rec.sport, i_rec.dport, i_rec.protocol};

    // way lookup: first matching way, else first free way
    always_comb begin
        found    = 1'b0;
        has_free = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < frat_pkg::WAYS; w++) begin
            if (i_bucket_row[w].valid) begin
                if (!found && i_bucket_row[w].addrs == addrs && i_bucket_row[w].ppr == ppr) begin
                    found   = 1'b1;
                    hit_way = frat_pkg::WAY_W'(w);
                end
            end else if (!has_free) begin
                has_free = 1'b1;
                free_way = frat_pkg::WAY_W'(w);
            end
        end
        way  = found ? hit_way : free_way;
        drop = !found && !has_free;
    end

    // flow summary merge or new entry
    always_comb begin
        ent = i_bucket_row[way];
        if (found) begin
            ent.flags = ent.flags | i_rec.flag_bits;
            if (i_rec.first_sec < ent.start_t) begin
                ent.start_t = i_rec.first_sec;
            end
            if (i_rec.last_sec > ent.end_t) begin
                ent.end_t = i_rec.last_sec;
            end
        end else begin
            ent.valid   = 1'b1;
            ent.addrs   = addrs;
            ent.ppr     = ppr;
            ent.start_t = i_rec.first_sec;
            ent.end_t   = i_rec.last_sec;
            ent.flags   = i_rec.flag_bits;
            ent.total   = '0;
        end
        n = ent.total;
        if (n > frat_pkg::SRC_W'(frat_pkg::SOURCES_PER_FLOW)) begin
            n = frat_pkg::SRC_W'(frat_pkg::SOURCES_PER_FLOW);
        end
    end

    // exporter slot search among slots in use
    always_comb begin
        smatch = 1'b0;
        sidx   = '0;
        for (int s = 0; s < frat_pkg::SOURCES_PER_FLOW; s++) begin
            if (!smatch && frat_pkg::SRC_W'(s) < n
                    && i_slot_row[s].exporter == i_rec.exporter_addr) begin
                smatch = 1'b1;
                sidx   = frat_pkg::SLOT_W'(s);
            end
        end
        sadd = !smatch && (n < frat_pkg::SRC_W'(frat_pkg::SOURCES_PER_FLOW));
        if (sadd) begin
            sidx = frat_pkg::SLOT_W'(n);
        end
        slot = i_slot_row[sidx];
        if (smatch) begin
            slot.packets = slot.packets + {32'd0, i_rec.packet_count};
            slot.bytes   = slot.bytes + {32'd0, i_rec.byte_count};
            slot.records = slot.records + 64'd1;
            sstat        = frat_pkg::SRC_UPDATED;
        end else if (sadd) begin
            slot.exporter = i_rec.exporter_addr;
            slot.packets  = {32'd0, i_rec.packet_count};
            slot.bytes    = {32'd0, i_rec.byte_count};
            slot.records  = 64'd1;
            sstat         = frat_pkg::SRC_ADDED;
        end else begin
            sstat = frat_pkg::SRC_NONE;
        end
    end

    // write-back rows and result
    always_comb begin
        frat_pkg::t_entry ent_wr;
        ent_wr = ent;
        if (sadd) begin
            ent_wr.total = n + frat_pkg::SRC_W'(1);
        end
        o_merge.way        = way;
        o_merge.bucket_we  = !drop;
        o_merge.slot_we    = !drop && (smatch || sadd);
        o_merge.bucket_row = i_bucket_row;
        o_merge.bucket_row[way] = ent_wr;
        o_merge.slot_row   = i_slot_row;
        o_merge.slot_row[sidx]  = slot;
        o_merge.result     = '0;
        o_merge.result.hash_value = i_hash;
        if (drop) begin
            o_merge.result.flow_status   = frat_pkg::FLOW_DROPPED;
            o_merge.result.source_status = frat_pkg::SRC_NONE;
        end else begin
            o_merge.result.flow_status   = found ? frat_pkg::FLOW_MERGED : frat_pkg::FLOW_NEW;
            o_merge.result.source_status = sstat;
            // total never exceeds the slot count: it grows only below it
            o_merge.result.source_total  = 5'(ent_wr.total);
            o_merge.result.merged_flags  = ent.flags;
            o_merge.result.merged_start  = ent.start_t;
            o_merge.result.merged_end    = ent.end_t;
            if (smatch || sadd) begin
                o_merge.result.exporter_packets = slot.packets;
                o_merge.result.exporter_bytes   = slot.bytes;
                o_merge.result.exporter_records = slot.records;
            end
        end
    end

endmodule

@@ sv/flow_record_aggregation_table_top.sv @@
// top level of the flow record aggregation table: sequencer, clearing pass, memories
//
//  channel   ports                      transfer
//  record    i_start, i_in, o_busy      edge with i_start high and o_busy low
//  result    o_done, o_out              edge ending the one cycle o_done is high
//
//  each record passes through a bucket row read, an exporter slot row read, then merge and write-back
//  the slot row address comes from the way found in the bucket row, so the two reads are serial
//  a new record is accepted in the cycle its result is shown
//  after reset a clearing pass writes every bucket row once, with busy high
//  the receiver cannot stall; results are never held
module flow_record_aggregation_table_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  frat_pkg::t_in  i_in,
    output logic           o_busy,
    output logic           o_done,
    output frat_pkg::t_out o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAG,
        S_SLOT
    } t_state;

    t_state                             r_state, n_state;
    logic                               r_clr_active;
    logic [frat_pkg::BUCKET_BITS-1:0]   r_clr_addr;
    frat_pkg::t_in                      r_rec;
    logic [15:0]                        r_hash;
    logic                               r_done;
    frat_pkg::t_out                     r_out;

    logic                               accept;
    logic [15:0]                        in_hash;
    logic [frat_pkg::BUCKET_ROW_W-1:0]  bucket_rdata;
    logic [frat_pkg::SLOT_ROW_W-1:0]    slot_rdata;
    frat_pkg::t_merge                   merge;
    logic                               bkt_we;
    logic [frat_pkg::BUCKET_BITS-1:0]   bkt_waddr;
    logic [frat_pkg::BUCKET_ROW_W-1:0]  bkt_wdata;
    logic [frat_pkg::ENTRY_W-1:0]       entry_idx;

    assign o_busy  = r_clr_active || (r_state != S_IDLE);
    assign accept  = i_start && !o_busy;
    assign in_hash = frat_pkg::key_hash(i_in);

    // entry index of the selected way
    assign entry_idx = frat_pkg::ENTRY_W'(r_hash[frat_pkg::BUCKET_BITS-1:0])
                     * frat_pkg::ENTRY_W'(frat_pkg::WAYS)
                     + frat_pkg::ENTRY_W'(merge.way);

    // bucket write port shared by clearing pass and write-back
    always_comb begin
        if (r_clr_active) begin
            bkt_we    = 1'b1;
            bkt_waddr = r_clr_addr;
            bkt_wdata = '0;
        end else begin
            bkt_we    = (r_state == S_SLOT) && merge.bucket_we;
            bkt_waddr = r_hash[frat_pkg::BUCKET_BITS-1:0];
            bkt_wdata = merge.bucket_row;
        end
    end

    frat_ram #(
        .WIDTH (frat_pkg::BUCKET_ROW_W),
        .DEPTH (frat_pkg::NUM_BUCKETS)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_re    (accept),
        .i_raddr (in_hash[frat_pkg::BUCKET_BITS-1:0]),
        .o_rdata (bucket_rdata)
    );

    frat_ram #(
        .WIDTH (frat_pkg::SLOT_ROW_W),
        .DEPTH (frat_pkg::NUM_ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_SLOT) && merge.slot_we),
        .i_waddr (entry_idx),
        .i_wdata (merge.slot_row),
        .i_re    (r_state == S_TAG),
        .i_raddr (entry_idx),
        .o_rdata (slot_rdata)
    );

    frat_merge u_merge (
        .i_rec        (r_rec),
        .i_hash       (r_hash),
        .i_bucket_row (bucket_rdata),
        .i_slot_row   (slot_rdata),
        .o_merge      (merge)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_TAG;
            S_TAG:   n_state = S_SLOT;
            S_SLOT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer, clearing pass and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_SLOT);
            if (r_state == S_SLOT) begin
                r_out <= merge.result;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + frat_pkg::BUCKET_BITS'(1);
                if (r_clr_addr == frat_pkg::BUCKET_BITS'(frat_pkg::NUM_BUCKETS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rec  <= i_in;
            r_hash <= in_hash;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef ASSERT_OFF
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results on consecutive cycles");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("not busy after a record transfer");
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (r_state == S_IDLE))
        else $error("record in flight during clearing pass");
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.flow_status == frat_pkg::FLOW_DROPPED)
            |-> (o_out.source_total == 5'd0 && o_out.exporter_records == 64'd0))
        else $error("dropped record carries totals");
`endif

endmodule
